FILE: hw/rtl/skoi_pkg.sv
package skoi_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int MAX_OFFSETS = 16;
   localparam int OFFSET_BITS = 32;

   localparam int KEY_W   = 29;
   localparam int POS_W   = $clog2(MAX_ENTRIES);
   localparam int USED_W  = POS_W + 1;
   localparam int SLOT_W  = $clog2(MAX_OFFSETS);
   localparam int CNT_W   = 5;
   localparam int ADDR_W  = POS_W + SLOT_W;

   typedef enum logic [1:0] {
      MODE_ADD  = 2'd0,
      MODE_FIND = 2'd1,
      MODE_GET  = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_NEW       = 3'd0,
      ST_APPENDED  = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_TABLE_FULL = 3'd4,
      ST_LIST_FULL = 3'd5,
      ST_POS_BAD   = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH,
      S_CMP,
      S_HIT,
      S_RPT_RD,
      S_RPT_OUT,
      S_SH_RD,
      S_SH_WR,
      S_EMIT
   } state_type;

   // One table row: the key, the number of offsets and the physical slot
   // whose offset list belongs to it. Rows move on insert, lists never do.
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [CNT_W-1:0]  cnt;
      logic [POS_W-1:0]  slot;
   } ent_type;

   typedef struct packed {
      logic [POS_W-1:0]       ent_raddr;
      logic                   ent_we;
      logic [POS_W-1:0]       ent_waddr;
      ent_type                ent_wdata;
      logic [ADDR_W-1:0]      off_raddr;
      logic                   off_we;
      logic [ADDR_W-1:0]      off_waddr;
      logic [OFFSET_BITS-1:0] off_wdata;
   } mem_req_type;

   typedef struct packed {
      status_type        status;
      logic [KEY_W-1:0]  key;
      logic [31:0]       offset;
      logic [POS_W-1:0]  pos;
      logic [CNT_W-1:0]  cnt;
      logic [USED_W-1:0] total;
   } rsp_type;

endpackage

FILE: hw/rtl/sorted_key_offset_index.sv
// A key search is a binary search of at most 7 halving steps for 64 rows, each a row read
// (S_SRCH) and a compare (S_CMP). Add and miss results leave through S_EMIT; a new entry
// first moves each row above it up one place. Reports read and send one offset at a time.
// One item at a time: a new request is taken only in S_IDLE, once the last response of the
// previous item is registered. The search and the row shift share the row memory's read.
// Reset (synchronous, active high) empties the table; row and offset memories are not cleared.
module sorted_key_offset_index (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [28:0] req_field_key,
   input  logic [31:0] req_offset_value,
   input  logic [5:0]  req_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [28:0] rsp_result_key,
   output logic [31:0] rsp_result_offset,
   output logic [5:0]  rsp_result_position,
   output logic [4:0]  rsp_offset_count,
   output logic [6:0]  rsp_entry_total,
   output logic        rsp_last
);
   import skoi_pkg::*;

   mem_req_type            mem_req;
   ent_type                ent_rd;
   logic [OFFSET_BITS-1:0] off_rd;
   rsp_type                rsp_data;

   skoi_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .ent_rd  (ent_rd),
      .off_rd  (off_rd)
   );

   skoi_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_field_key    (req_field_key),
      .req_offset_value (req_offset_value),
      .req_position     (req_position),
      .mem_req          (mem_req),
      .ent_rd           (ent_rd),
      .off_rd           (off_rd),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .rsp_last         (rsp_last)
   );

   assign rsp_status          = rsp_data.status;
   assign rsp_result_key      = rsp_data.key;
   assign rsp_result_offset   = rsp_data.offset;
   assign rsp_result_position = rsp_data.pos;
   assign rsp_offset_count    = rsp_data.cnt;
   assign rsp_entry_total     = rsp_data.total;
endmodule

FILE: hw/rtl/skoi_store.sv
module skoi_store (
   input  logic                                clock,
   input  skoi_pkg::mem_req_type               mem_req,
   output skoi_pkg::ent_type                   ent_rd,
   output logic [skoi_pkg::OFFSET_BITS-1:0]    off_rd
);
   import skoi_pkg::*;

   ent_type                ent_mem [MAX_ENTRIES];
   logic [OFFSET_BITS-1:0] off_mem [MAX_ENTRIES*MAX_OFFSETS];

   always_ff @(posedge clock) begin
      if (mem_req.ent_we) begin
         ent_mem[mem_req.ent_waddr] <= mem_req.ent_wdata;
      end
      ent_rd <= ent_mem[mem_req.ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (mem_req.off_we) begin
         off_mem[mem_req.off_waddr] <= mem_req.off_wdata;
      end
      off_rd <= off_mem[mem_req.off_raddr];
   end

endmodule

FILE: hw/rtl/skoi_ctrl.sv
module skoi_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic [skoi_pkg::KEY_W-1:0]          req_field_key,
   input  logic [31:0]                         req_offset_value,
   input  logic [5:0]                          req_position,
   output skoi_pkg::mem_req_type               mem_req,
   input  skoi_pkg::ent_type                   ent_rd,
   input  logic [skoi_pkg::OFFSET_BITS-1:0]    off_rd,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output skoi_pkg::rsp_type                   rsp_data,
   output logic                                rsp_last
);
   import skoi_pkg::*;

   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [USED_W-1:0]      lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in, used_ff, used_in;
   logic [USED_W-1:0]      mid;
   ent_type                hold_ff, hold_in;
   rsp_type                pend_ff, pend_in, rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in, last_ff, last_in;
   logic                   out_free, accept, hit, rpt_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && (state_ff == S_IDLE);
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign hit      = (lo_ff < used_ff) && (ent_rd.key == key_ff);
   assign rpt_last = (idx_ff + USED_W'(1)) == USED_W'(hold_ff.cnt);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (mode_type'(req_mode) == MODE_NONE) state_in = S_IDLE;
               else if (mode_type'(req_mode) == MODE_GET &&
                        USED_W'(req_position) >= used_ff) state_in = S_EMIT;
               else state_in = S_SRCH;
            end
         end
         S_SRCH: state_in = (lo_ff < hi_ff) ? S_CMP : S_HIT;
         S_CMP:  state_in = S_SRCH;
         S_HIT: begin
            priority if (mode_ff == MODE_GET || (mode_ff == MODE_FIND && hit))
               state_in = S_RPT_RD;
            else if (mode_ff == MODE_ADD && !hit && used_ff < USED_W'(MAX_ENTRIES))
               state_in = S_SH_RD;
            else state_in = S_EMIT;
         end
         S_RPT_RD:  state_in = S_RPT_OUT;
         S_RPT_OUT: begin
            if (out_free) state_in = rpt_last ? S_IDLE : S_RPT_RD;
         end
         S_SH_RD: state_in = (idx_ff == lo_ff) ? S_EMIT : S_SH_WR;
         S_SH_WR: state_in = S_SH_RD;
         S_EMIT:  begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      key_in = key_ff;
      off_in = off_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      idx_in = idx_ff;
      used_in = used_ff;
      hold_in = hold_ff;
      pend_in = pend_ff;
      rsp_in = rsp_ff;
      last_in = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_req = '0;
      mem_req.ent_raddr = '0;
      mem_req.off_raddr = {hold_ff.slot, idx_ff[SLOT_W-1:0]};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in = mode_type'(req_mode);
               key_in = req_field_key;
               off_in = OFFSET_BITS'(req_offset_value);
               if (mode_type'(req_mode) == MODE_GET) begin
                  lo_in = USED_W'(req_position);
                  hi_in = USED_W'(req_position);
                  pend_in = '{ST_POS_BAD, '0, '0, req_position, '0, used_ff};
               end else begin
                  lo_in = '0;
                  hi_in = used_ff;
               end
            end
         end
         S_SRCH: begin
            mem_req.ent_raddr = (lo_ff < hi_ff) ? mid[POS_W-1:0] : lo_ff[POS_W-1:0];
         end
         S_CMP: begin
            if (ent_rd.key < key_ff) lo_in = mid + USED_W'(1);
            else hi_in = mid;
         end
         S_HIT: begin
            hold_in = ent_rd;
            idx_in = '0;
            if (mode_ff == MODE_FIND && !hit) begin
               pend_in = '{ST_NOT_FOUND, key_ff, '0, '0, '0, used_ff};
            end else if (mode_ff == MODE_ADD && hit) begin
               if (ent_rd.cnt >= CNT_W'(MAX_OFFSETS)) begin
                  pend_in = '{ST_LIST_FULL, key_ff, '0, lo_ff[POS_W-1:0], ent_rd.cnt,
                              used_ff};
               end else begin
                  mem_req.off_we = 1'b1;
                  mem_req.off_waddr = {ent_rd.slot, ent_rd.cnt[SLOT_W-1:0]};
                  mem_req.off_wdata = off_ff;
                  mem_req.ent_we = 1'b1;
                  mem_req.ent_waddr = lo_ff[POS_W-1:0];
                  mem_req.ent_wdata = '{ent_rd.key, ent_rd.cnt + CNT_W'(1), ent_rd.slot};
                  pend_in = '{ST_APPENDED, key_ff, 32'(off_ff), lo_ff[POS_W-1:0],
                              ent_rd.cnt + CNT_W'(1), used_ff};
               end
            end else if (mode_ff == MODE_ADD) begin
               idx_in = used_ff;
               pend_in = '{ST_TABLE_FULL, key_ff, '0, '0, '0, used_ff};
            end
         end
         S_RPT_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{ST_FOUND, hold_ff.key, 32'(off_rd), lo_ff[POS_W-1:0],
                          hold_ff.cnt, used_ff};
               last_in = rpt_last;
               idx_in = idx_ff + USED_W'(1);
            end
         end
         S_SH_RD: begin
            mem_req.ent_raddr = idx_ff[POS_W-1:0] - POS_W'(1);
            if (idx_ff == lo_ff) begin
               // Rows are in place; the new row takes the next unused slot.
               mem_req.ent_we = 1'b1;
               mem_req.ent_waddr = lo_ff[POS_W-1:0];
               mem_req.ent_wdata = '{key_ff, CNT_W'(1), used_ff[POS_W-1:0]};
               mem_req.off_we = 1'b1;
               mem_req.off_waddr = {used_ff[POS_W-1:0], {SLOT_W{1'b0}}};
               mem_req.off_wdata = off_ff;
               used_in = used_ff + USED_W'(1);
               pend_in = '{ST_NEW, key_ff, 32'(off_ff), lo_ff[POS_W-1:0], CNT_W'(1),
                           used_ff + USED_W'(1)};
            end
         end
         S_SH_WR: begin
            mem_req.ent_we = 1'b1;
            mem_req.ent_waddr = idx_ff[POS_W-1:0];
            mem_req.ent_wdata = ent_rd;
            idx_in = idx_ff - USED_W'(1);
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = pend_ff;
               last_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      key_ff <= key_in;
      off_ff <= off_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      idx_ff <= idx_in;
      hold_ff <= hold_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
      last_ff <= last_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign rsp_last = last_ff;

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(MAX_ENTRIES)) else $error("entry count out of range");
   a_used_only_insert: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SH_RD) |=> $stable(used_ff)) else $error("count changed outside insert");
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH) |-> (lo_ff <= hi_ff)) else $error("search bounds crossed");
   a_shift_above: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SH_WR) |-> (idx_ff > lo_ff)) else $error("shift below insert point");
endmodule

FILE: tb/sv/sorted_key_offset_index_checker.sv
module sorted_key_offset_index_checker
   import skoi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [28:0] req_field_key,
   input  logic [31:0] req_offset_value,
   input  logic [5:0]  req_position,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [28:0] rsp_result_key,
   input  logic [31:0] rsp_result_offset,
   input  logic [5:0]  rsp_result_position,
   input  logic [4:0]  rsp_offset_count,
   input  logic [6:0]  rsp_entry_total,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      status_type        status;
      logic [28:0]       key;
      logic [31:0]       offset;
      logic [5:0]        pos;
      logic [4:0]        cnt;
      logic [6:0]        total;
      logic              last;
   } expected_item_type;

   expected_item_type pending_q[$];

   logic [28:0] row_key [MAX_ENTRIES];
   logic [4:0]  row_cnt [MAX_ENTRIES];
   logic [31:0] row_off [MAX_ENTRIES][MAX_OFFSETS];
   int          rows_used;

   assign pending_count = pending_q.size();

   function automatic expected_item_type make_item(status_type st, logic [28:0] k,
         logic [31:0] off, logic [5:0] p, logic [4:0] c, logic lst);
      expected_item_type e;
      e.status = st;
      e.key    = k;
      e.offset = off;
      e.pos    = p;
      e.cnt    = c;
      e.total  = 7'(rows_used);
      e.last   = lst;
      return e;
   endfunction

   task automatic push_listing(int row);
      for (int j = 0; j < row_cnt[row]; j++)
         pending_q.push_back(make_item(ST_FOUND, row_key[row], row_off[row][j],
            6'(row), row_cnt[row], j + 1 == row_cnt[row]));
   endtask

   // Applies one item to the shadow table and queues what it should produce.
   task automatic predict_index(logic [1:0] mode, logic [28:0] k, logic [31:0] off,
         logic [5:0] p);
      int lo;
      int hi;
      int mid;
      bit hit;
      lo = 0;
      hi = rows_used;
      if (mode == MODE_NONE) return;
      if (mode == MODE_GET) begin
         if (p >= rows_used) pending_q.push_back(make_item(ST_POS_BAD, 0, 0, p, 0, 1));
         else push_listing(p);
         return;
      end
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (row_key[mid] < k) lo = mid + 1;
         else hi = mid;
      end
      hit = lo < rows_used && row_key[lo] == k;
      if (mode == MODE_FIND) begin
         if (!hit) pending_q.push_back(make_item(ST_NOT_FOUND, k, 0, 0, 0, 1));
         else push_listing(lo);
      end else if (hit) begin
         if (row_cnt[lo] >= MAX_OFFSETS) begin
            pending_q.push_back(make_item(ST_LIST_FULL, k, 0, 6'(lo), row_cnt[lo], 1));
         end else begin
            row_off[lo][row_cnt[lo]] = off;
            row_cnt[lo]++;
            pending_q.push_back(make_item(ST_APPENDED, k, off, 6'(lo), row_cnt[lo], 1));
         end
      end else if (rows_used >= MAX_ENTRIES) begin
         pending_q.push_back(make_item(ST_TABLE_FULL, k, 0, 0, 0, 1));
      end else begin
         for (int i = rows_used; i > lo; i--) begin
            row_key[i] = row_key[i-1];
            row_cnt[i] = row_cnt[i-1];
            row_off[i] = row_off[i-1];
         end
         row_key[lo]    = k;
         row_cnt[lo]    = 1;
         row_off[lo][0] = off;
         rows_used++;
         pending_q.push_back(make_item(ST_NEW, k, off, 6'(lo), 1, 1));
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      rows_used  = 0;
   end

   always @(posedge clock) begin
      expected_item_type e;
      if (reset) begin
         rows_used = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_q.size() == 0) begin
               report_mismatch("unexpected item, status", rsp_status, 0);
            end else begin
               e = pending_q.pop_front();
               if (rsp_status != e.status) report_mismatch("status", rsp_status, e.status);
               if (rsp_result_key != e.key) report_mismatch("key", rsp_result_key, e.key);
               if (rsp_result_offset != e.offset)
                  report_mismatch("offset", rsp_result_offset, e.offset);
               if (rsp_result_position != e.pos)
                  report_mismatch("position", rsp_result_position, e.pos);
               if (rsp_offset_count != e.cnt)
                  report_mismatch("offset_count", rsp_offset_count, e.cnt);
               if (rsp_entry_total != e.total)
                  report_mismatch("entry_total", rsp_entry_total, e.total);
               if (rsp_last != e.last) report_mismatch("last", rsp_last, e.last);
            end
         end
         if (req_valid && !req_stall)
            predict_index(req_mode, req_field_key, req_offset_value, req_position);
      end
   end

endmodule

FILE: tb/sv/sorted_key_offset_index_tb.sv
module sorted_key_offset_index_tb;
   import skoi_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_mode = MODE_NONE;
   logic [28:0] req_field_key = 0;
   logic [31:0] req_offset_value = 0;
   logic [5:0]  req_position = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_status;
   logic [28:0] rsp_result_key;
   logic [31:0] rsp_result_offset;
   logic [5:0]  rsp_result_position;
   logic [4:0]  rsp_offset_count;
   logic [6:0]  rsp_entry_total;
   logic        rsp_last;
   int          fail_count;
   int          pending_count;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_cycles = 0;
   int  quiet_cycles = 0;
   int  known_rows = 0;
   logic [28:0] used_keys[$];

   always #5 clock = ~clock;

   sorted_key_offset_index u_top (.*);

   sorted_key_offset_index_checker u_checker (.*);

   // The receiver stalls at random, or solidly while a hold is requested.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall   <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("sorted_key_offset_index_tb: errors");
         $finish;
      end
   end

   // Valid stays high from one item to the next unless the sender idles in between.
   task automatic send_item(logic [1:0] mode, logic [28:0] k, logic [31:0] off,
         logic [5:0] p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid        <= 1;
      req_mode         <= mode;
      req_field_key    <= k;
      req_offset_value <= off;
      req_position     <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Mostly keys that already exist so lists grow, sometimes fresh ones.
   task automatic random_item();
      int pick;
      logic [28:0] k;
      pick = $urandom_range(99);
      if (used_keys.size() > 0 && $urandom_range(99) < 60)
         k = used_keys[$urandom_range(used_keys.size() - 1)];
      else begin
         k = $urandom_range(7) == 0 ? 29'($urandom) : 29'($urandom_range(200));
         if (used_keys.size() < 80) used_keys.push_back(k);
      end
      if (pick < 55) send_item(MODE_ADD, k, $urandom, 6'($urandom));
      else if (pick < 75) send_item(MODE_FIND, $urandom_range(3) == 0 ? 29'($urandom) : k,
         $urandom, 6'($urandom));
      else if (pick < 95) send_item(MODE_GET, 29'($urandom), $urandom, 6'($urandom));
      else send_item(MODE_NONE, 29'($urandom), $urandom, 6'($urandom));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_idle_pct = 12;
      recv_idle_pct = 75;
      // Directed: empty table cases, extremes, lists filled up to the limit.
      send_item(MODE_FIND, 29'h1FFFFFFF, 0, 0);
      send_item(MODE_GET, 0, 0, 6'd0);
      send_item(MODE_GET, 0, 0, 6'd63);
      send_item(MODE_NONE, 29'h1FFFFFFF, 32'hFFFFFFFF, 6'd63);
      send_item(MODE_ADD, 29'h1FFFFFFF, 32'hFFFFFFFF, 6'd63);
      send_item(MODE_ADD, 29'd0, 32'd0, 6'd0);
      send_item(MODE_ADD, 29'd1000, 32'h5A5A5A5A, 6'd0);
      for (int i = 0; i < 16; i++) send_item(MODE_ADD, 29'd1000, 32'h1000 + i, 0);
      send_item(MODE_FIND, 29'd1000, 0, 0);
      send_item(MODE_GET, 0, 0, 6'd2);
      send_item(MODE_FIND, 29'h1FFFFFFF, 0, 0);
      send_item(MODE_GET, 0, 0, 6'd3);
      used_keys.push_back(29'd1000);

      // The receiver holds off while items keep coming, filling the block.
      hold_cycles = 300;
      for (int i = 0; i < 8; i++) send_item(MODE_FIND, 29'd1000, 0, 0);
      wait_drained();

      // Fill the table with fresh keys, then hit table full.
      send_idle_pct = 75;
      recv_idle_pct = 12;
      for (int i = 0; i < 61; i++) send_item(MODE_ADD, 29'(5000 + 3 * i), $urandom, 0);
      send_item(MODE_ADD, 29'd1, 32'hFFFFFFFF, 0);
      send_item(MODE_ADD, 29'd5000, 32'h1, 0);
      send_item(MODE_GET, 0, 0, 6'd63);
      send_item(MODE_FIND, 29'd5003, 0, 0);
      wait_drained();

      // A fresh table cannot be had without reset, so the rest works on the full one
      // plus noise: appends, lookups and lists running into their limit.
      for (int i = 0; i < 61; i++) used_keys.push_back(29'(5000 + 3 * i));
      for (int i = 0; i < 110; i++) begin
         if (i == 55) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_item();
      end
      wait_drained();

      if (fail_count == 0) begin
         $display("sorted_key_offset_index_tb: clean");
      end else begin
         $display("sorted_key_offset_index_tb: errors");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/skoi_pkg.sv
hw/rtl/skoi_store.sv
hw/rtl/skoi_ctrl.sv
hw/rtl/sorted_key_offset_index.sv
tb/sv/sorted_key_offset_index_checker.sv
tb/sv/sorted_key_offset_index_tb.sv
